// File: rtl/core/led_pkg.sv
package led_pkg;

  // pixel channel layout
  localparam int CH_W  = 8;
  localparam int PIX_W = 3 * CH_W;

  // frame geometry
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int COL_W_DEF     = $clog2(MAX_WIDTH_DEF);
  localparam int ROW_W         = 12;
  localparam int RST_WIDTH     = 640;
  localparam int RST_HEIGHT    = 480;

  // configuration port
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [CH_W-1:0]  chan_t;
  typedef logic [PIX_W-1:0] pix_t;

  // |u + d + l + r - 4c| clamped to the channel range
  function automatic chan_t lap_chan(chan_t c, chan_t u, chan_t d, chan_t l, chan_t r);
    logic [CH_W+1:0] sum;
    logic [CH_W+1:0] cx4;
    logic [CH_W+1:0] diff;
    sum  = {2'b00, u} + {2'b00, d} + {2'b00, l} + {2'b00, r};
    cx4  = {c, 2'b00};
    diff = (sum >= cx4) ? (sum - cx4) : (cx4 - sum);
    return (diff > {2'b00, {CH_W{1'b1}}}) ? {CH_W{1'b1}} : diff[CH_W-1:0];
  endfunction

  // per-channel laplacian on packed r:g:b pixels
  function automatic pix_t lap_pix(pix_t c, pix_t u, pix_t d, pix_t l, pix_t r);
    pix_t res;
    for (int i = 0; i < 3; i++) begin
      res[i*CH_W +: CH_W] = lap_chan(c[i*CH_W +: CH_W], u[i*CH_W +: CH_W],
                                     d[i*CH_W +: CH_W], l[i*CH_W +: CH_W],
                                     r[i*CH_W +: CH_W]);
    end
    return res;
  endfunction

endpackage

// File: rtl/core/led_pix_if.sv
interface led_pix_if;
  import led_pkg::*;

  logic  valid;
  logic  ready;
  chan_t red_in;
  chan_t green_in;
  chan_t blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

// File: rtl/core/led_res_if.sv
interface led_res_if #(
  parameter int COL_W = led_pkg::COL_W_DEF
);
  import led_pkg::*;

  logic             valid;
  logic             ready;
  chan_t            red_out;
  chan_t            green_out;
  chan_t            blue_out;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  logic             last_of_run;
  logic             frame_done;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output out_col, output out_row, output last_of_run,
                  output frame_done, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input out_col, input out_row, input last_of_run,
                  input frame_done, output ready);
endinterface

// File: rtl/core/led_ram.sv
module led_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/laplacian_edge_detect_rgb_unit.sv
// 4-neighbour laplacian edge detector for an r:g:b pixel stream.
// pix (sink) takes pixels in raster order, one transaction per pixel; res
// (source) gives clamped |laplacian| results tagged with column and row.
// cfg_we/cfg_index/cfg_data write frame_width (0) and frame_height (1);
// a write restarts the frame at column 0, row 0. Write only while idle.
// Pixel (x,y-1) comes out for input (x,y); on the last row (x-1,last)
// follows, and the final input of the frame also gives (W-1,last) with
// frame_done set. last_of_run marks the last result of one input.
// The first row of a frame gives no result (unless the frame has one row).
// Results go into a queue and are offered on res in the order of their inputs.
// Throughput: one pixel per clock while one result per pixel comes out;
// on the last row the single result port sets the pace, two results per
// pixel (three on the final one) at one result per clock.
// Results wait in a four-entry queue; pix.ready drops while two or more
// are queued, so a stalled receiver stalls the source without loss.
// Reset: frame 640 x 480, counters and queue cleared; the line stores are
// not cleared and need no clearing pass, as every entry read has been
// written earlier in the frame.
module laplacian_edge_detect_rgb_unit #(
  parameter int MAX_WIDTH = led_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [led_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [led_pkg::CFG_W-1:0]     cfg_data,
  led_pix_if.sink                       pix,
  led_res_if.source                     res
);
  import led_pkg::*;

  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int WW           = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
  localparam int RST_LAST_COL = ((RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH) - 1;
  localparam int QDEPTH       = 4;
  localparam int PTR_W        = $clog2(QDEPTH);
  localparam int CNT_W        = $clog2(QDEPTH + 1);

  typedef struct packed {
    pix_t             pix;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
    logic             done;
  } result_t;

  // frame geometry, held as last column and last row
  logic [COL_W-1:0] last_col;
  logic [COL_W-1:0] last_col_next;
  logic [ROW_W-1:0] last_row;
  logic [ROW_W-1:0] last_row_next;
  logic [WW-1:0]    width_ext;
  cfg_reg_t         cfg_reg;

  assign width_ext = WW'(cfg_data);
  assign cfg_reg   = cfg_reg_t'(cfg_index);

  always_comb begin
    priority if (cfg_data == '0) begin
      last_col_next = '0;
    end else if (width_ext > WW'(MAX_WIDTH)) begin
      last_col_next = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_col_next = COL_W'(width_ext - WW'(1));
    end
    last_row_next = (cfg_data == '0) ? '0 : ROW_W'(cfg_data - CFG_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_col <= COL_W'(RST_LAST_COL);
      last_row <= ROW_W'(RST_HEIGHT - 1);
    end else if (cfg_we) begin
      unique case (cfg_reg)
        REG_FRAME_WIDTH:  last_col <= last_col_next;
        REG_FRAME_HEIGHT: last_row <= last_row_next;
        default: ;
      endcase
    end
  end

  // raster position
  logic             acc;
  logic [COL_W-1:0] col;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] row_next;
  logic [CNT_W-1:0] count;

  assign acc = pix.valid && pix.ready;

  always_comb begin
    col_next = col;
    row_next = row;
    priority if (cfg_we) begin
      col_next = '0;
      row_next = '0;
    end else if (acc) begin
      if (col == last_col) begin
        col_next = '0;
        row_next = (row == last_row) ? '0 : row + ROW_W'(1);
      end else begin
        col_next = col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
    end
  end

  // line stores: reads follow the next position so data is ready on arrival
  pix_t             cur;
  pix_t             newer_a_q;
  pix_t             newer_b_q;
  pix_t             older_q;
  pix_t             cur_d1;
  pix_t             cur_d2;
  pix_t             above_d1;
  pix_t             c0;
  pix_t             u2;
  pix_t             rn;
  logic [COL_W-1:0] rd_a;
  logic [COL_W-1:0] rd_b;
  logic             hit_a;
  logic             hit_b;

  assign cur  = {pix.red_in, pix.green_in, pix.blue_in};
  assign rd_a = col_next;
  assign rd_b = col_next + COL_W'(1);

  led_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer_a (
    .clk(clk), .we(acc), .waddr(col), .wdata(cur), .raddr(rd_a), .rdata(newer_a_q)
  );

  led_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer_b (
    .clk(clk), .we(acc), .waddr(col), .wdata(cur), .raddr(rd_b), .rdata(newer_b_q)
  );

  led_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk(clk), .we(acc), .waddr(col), .wdata(c0), .raddr(rd_a), .rdata(older_q)
  );

  // forward the write when a narrow frame reads the entry just written
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_a <= 1'b0;
      hit_b <= 1'b0;
    end else begin
      hit_a <= acc && (rd_a == col);
      hit_b <= acc && (rd_b == col);
    end
  end

  assign c0 = hit_a ? cur_d1   : newer_a_q;
  assign u2 = hit_a ? above_d1 : older_q;
  assign rn = hit_b ? cur_d1   : newer_b_q;

  // recent pixels of this row and the row above
  always_ff @(posedge clk) begin
    if (acc) begin
      cur_d1   <= cur;
      cur_d2   <= cur_d1;
      above_d1 <= c0;
    end
  end

  // the up to three results of one input
  logic    x0, x1, xl, y0, y1, yl;
  logic    v0, v1, v2;
  logic [1:0] n;
  result_t r0, r1, r2;
  result_t slot [3];

  assign x0 = (col == '0);
  assign x1 = (col == COL_W'(1));
  assign xl = (col == last_col);
  assign y0 = (row == '0);
  assign y1 = (row == ROW_W'(1));
  assign yl = (row == last_row);
  assign v0 = !y0;
  assign v1 = yl && !x0;
  assign v2 = yl && xl;
  assign n  = {1'b0, v0} + {1'b0, v1} + {1'b0, v2};

  always_comb begin
    // pixel above the current input
    r0.pix  = lap_pix(c0, y1 ? c0 : u2, cur, x0 ? c0 : above_d1, xl ? c0 : rn);
    r0.col  = col;
    r0.row  = row - ROW_W'(1);
    r0.last = 1'b0;
    r0.done = 1'b0;
    // left neighbour on the last row
    r1.pix  = lap_pix(cur_d1, y0 ? cur_d1 : above_d1, cur_d1,
                      x1 ? cur_d1 : cur_d2, cur);
    r1.col  = col - COL_W'(1);
    r1.row  = row;
    r1.last = 1'b0;
    r1.done = 1'b0;
    // final pixel of the frame
    r2.pix  = lap_pix(cur, y0 ? cur : c0, cur, x0 ? cur : cur_d1, cur);
    r2.col  = col;
    r2.row  = row;
    r2.last = 1'b0;
    r2.done = 1'b1;
    // pack the valid results in order
    slot[0] = v0 ? r0 : (v1 ? r1 : r2);
    slot[1] = (v0 && v1) ? r1 : r2;
    slot[2] = r2;
    slot[0].last = (n == 2'd1);
    slot[1].last = (n == 2'd2);
    slot[2].last = (n == 2'd3);
  end

  // result queue
  result_t          queue [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] push_n;
  logic             pop;
  result_t          head;

  assign push_n = acc ? CNT_W'(n) : '0;
  assign pop    = res.valid && res.ready;

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      logic [PTR_W-1:0] offs;
      offs = PTR_W'(i) - wr_ptr;
      if (acc && (CNT_W'(offs) < CNT_W'(n))) begin
        unique case (offs)
          PTR_W'(0): queue[i] <= slot[0];
          PTR_W'(1): queue[i] <= slot[1];
          PTR_W'(2): queue[i] <= slot[2];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + push_n - CNT_W'(pop);
    end
  end

  assign pix.ready = !rst && (count <= CNT_W'(1));

  // output channel
  assign head            = queue[rd_ptr];
  assign res.valid       = (count != '0);
  assign res.red_out     = head.pix[2*CH_W +: CH_W];
  assign res.green_out   = head.pix[CH_W +: CH_W];
  assign res.blue_out    = head.pix[0 +: CH_W];
  assign res.out_col     = head.col;
  assign res.out_row     = head.row;
  assign res.last_of_run = head.last;
  assign res.frame_done  = head.done;

  // checks
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QDEPTH))
    else $error("result queue overrun");

  a_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    (col <= last_col) && (row <= last_row))
    else $error("raster position outside frame");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.frame_done) |-> res.last_of_run)
    else $error("frame_done without last_of_run");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (acc && (col == last_col) && (row == last_row)) |=> ((col == '0) && (row == '0)))
    else $error("raster position did not wrap at end of frame");
endmodule
